@@ hdl/csd_pkg.sv @@
// ----------------------------------------------------------------------------
// csd_pkg: shared types and constants of the curve grid snap block
// Widths, register indexes and the structs passed between the sub-units.
// ----------------------------------------------------------------------------
package csd_pkg;

  // point dimensionality and derived index width
  localparam int unsigned DIMS     = 2;
  localparam int unsigned DimW     = (DIMS > 1) ? $clog2(DIMS) : 1;

  // field widths
  localparam int unsigned ValW     = 32;
  localparam int unsigned StepW    = 31;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned NumShift = 4;
  localparam int unsigned ShIdxW   = $clog2(NumShift);
  localparam int unsigned CntW     = $clog2(ValW);

  localparam logic [StepW-1:0] GridStepRst = StepW'(590);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_GRID_STEP = 3'd0,
    REG_SHIFT_0   = 3'd1,
    REG_SHIFT_1   = 3'd2,
    REG_SHIFT_2   = 3'd3,
    REG_SHIFT_3   = 3'd4
  } cfg_reg_e;

  // per-coordinate tag carried alongside the snapping work
  typedef struct packed {
    logic [DimW-1:0] dim;
    logic            complete;
    logic            curve_end;
  } coord_tag_t;

  // snapped coordinate handed to the dedup unit
  typedef struct packed {
    logic [ValW-1:0] value;
    coord_tag_t      tag;
  } snap_res_t;

  // remainder unit request and response
  typedef struct packed {
    logic            start;
    logic [ValW-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [StepW-1:0] remainder;
  } div_rsp_t;

endpackage

@@ hdl/csd_intf.sv @@
// ----------------------------------------------------------------------------
// csd_intf: valid/ready channels of the curve grid snap block
// Coordinate input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface csd_coord_if;
  logic                             valid;
  logic                             ready;
  logic signed [csd_pkg::ValW-1:0]  coord_value;
  logic                             point_end;
  logic                             curve_end;

  modport source (output valid, coord_value, point_end, curve_end, input ready);
  modport sink   (input valid, coord_value, point_end, curve_end, output ready);
endinterface

interface csd_res_if;
  logic                             valid;
  logic                             ready;
  logic signed [csd_pkg::ValW-1:0]  snapped_value;
  logic                             point_last;
  logic                             curve_last;
  logic                             marker_only;

  modport source (output valid, snapped_value, point_last, curve_last, marker_only,
                  input ready);
  modport sink   (input valid, snapped_value, point_last, curve_last, marker_only,
                  output ready);
endinterface

interface csd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [csd_pkg::CfgIdxW-1:0]   index;
  logic [csd_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/csd_rem_div.sv @@
// ----------------------------------------------------------------------------
// csd_rem_div: bit-serial restoring remainder unit
// Shifts the dividend in one bit per cycle and keeps the partial remainder.
// ----------------------------------------------------------------------------
module csd_rem_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  csd_pkg::div_req_t        req_i,
  input  logic [csd_pkg::StepW-1:0] divisor_i,
  output csd_pkg::div_rsp_t        rsp_o
);
  import csd_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ValW-1:0]  num_q, num_d;
  logic [StepW-1:0] rem_q, rem_d;

  logic [StepW:0]   trial;
  logic [StepW+1:0] diff;

  // trial subtraction of the pitch from the shifted remainder
  assign trial = {rem_q, num_q[ValW-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor_i};

  // iteration control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = req_i.dividend;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[ValW-2:0], 1'b0};
      rem_d = diff[StepW+1] ? trial[StepW-1:0] : diff[StepW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(ValW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

@@ hdl/csd_snap.sv @@
// ----------------------------------------------------------------------------
// csd_snap: snaps one coordinate to the shifted grid
// Offset removal, magnitude, serial floor remainder, rounding and saturation.
// ----------------------------------------------------------------------------
module csd_snap (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [csd_pkg::ValW-1:0]  coord_i,
  input  logic [csd_pkg::StepW-1:0] shift_i,
  input  logic [csd_pkg::StepW-1:0] step_i,
  input  csd_pkg::coord_tag_t       tag_i,
  output logic                      idle_o,
  output logic                      res_valid_o,
  output csd_pkg::snap_res_t        res_o,
  input  logic                      res_ready_i
);
  import csd_pkg::*;

  localparam int unsigned DW = ValW + 1;
  localparam int unsigned SW = ValW + 2;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ABS  = 6'b000010,
    S_DIV  = 6'b000100,
    S_RND  = 6'b001000,
    S_ADD  = 6'b010000,
    S_DONE = 6'b100000
  } snap_state_e;

  snap_state_e      state_q, state_d;
  logic [ValW-1:0]  x_q;
  logic [DW-1:0]    d_q, mag;
  logic [StepW-1:0] r_q;
  logic [DW-1:0]    t_q;
  logic [ValW-1:0]  y_q;
  coord_tag_t       tag_q;
  logic             neg;
  logic             round_up;
  logic [SW-1:0]    sum;
  logic [ValW-1:0]  sat;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign neg = d_q[DW-1];
  assign mag = neg ? (~d_q + 1'b1) : d_q;

  // serial remainder unit
  assign div_req.start    = (state_q == S_ABS);
  assign div_req.dividend = mag[ValW-1:0];

  csd_rem_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .divisor_i (step_i),
    .rsp_o     (div_rsp)
  );

  // rounding decision: 2r > pitch, ties round down
  assign round_up = (r_q > (step_i >> 1));

  // add the correction and clamp to the coordinate range
  assign sum = {{2{x_q[ValW-1]}}, x_q} + {t_q[DW-1], t_q};
  always_comb begin
    if ((sum[SW-1] != sum[ValW-1]) || (sum[SW-2] != sum[ValW-1])) begin
      sat = sum[SW-1] ? {1'b1, {(ValW-1){1'b0}}} : {1'b0, {(ValW-1){1'b1}}};
    end else begin
      sat = sum[ValW-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start_i) state_d = S_ABS;
      S_ABS:  state_d = S_DIV;
      S_DIV:  if (div_rsp.done) state_d = S_RND;
      S_RND:  state_d = S_ADD;
      S_ADD:  state_d = S_DONE;
      S_DONE: if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      x_q   <= coord_i;
      d_q   <= {coord_i[ValW-1], coord_i} - {2'b00, shift_i};
      tag_q <= tag_i;
    end
    // floor remainder: negative offsets take the complement
    if (state_q == S_DIV && div_rsp.done) begin
      r_q <= (neg && (div_rsp.remainder != '0)) ? (step_i - div_rsp.remainder)
                                                 : div_rsp.remainder;
    end
    // correction: pitch minus remainder when rounding up, else minus remainder
    if (state_q == S_RND) begin
      t_q <= round_up ? ({2'b00, step_i} - {2'b00, r_q}) : ('0 - {2'b00, r_q});
    end
    if (state_q == S_ADD) begin
      y_q <= sat;
    end
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o.value = y_q;
  assign res_o.tag   = tag_q;

endmodule

@@ hdl/csd_emit.sv @@
// ----------------------------------------------------------------------------
// csd_emit: point assembly, duplicate drop and result sequencing
// Collects snapped coordinates, compares each point with the last one sent
// and plays the run out through an output register.
// ----------------------------------------------------------------------------
module csd_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               snap_valid_i,
  input  csd_pkg::snap_res_t snap_i,
  output logic               snap_ready_o,
  csd_res_if.source          result_o
);
  import csd_pkg::*;

  typedef enum logic [3:0] {
    E_IDLE = 4'b0001,
    E_CMP  = 4'b0010,
    E_RUN  = 4'b0100,
    E_MARK = 4'b1000
  } emit_state_e;

  emit_state_e     state_q, state_d;
  logic [ValW-1:0] cur_q  [DIMS];
  logic [ValW-1:0] prev_q [DIMS];
  logic            prev_valid_q;
  logic            cend_q;
  logic [DimW-1:0] idx_q;
  logic            same;
  logic            run_last;
  logic            slot_free;
  logic            out_valid_q;
  logic [ValW-1:0] out_value_q;
  logic            out_plast_q;
  logic            out_clast_q;
  logic            out_marker_q;

  assign slot_free = !out_valid_q || result_o.ready;
  assign run_last  = (idx_q == DimW'(DIMS - 1));

  // point equality against the last point sent
  always_comb begin
    same = 1'b1;
    for (int j = 0; j < DIMS; j++) begin
      if (cur_q[j] != prev_q[j]) same = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      E_IDLE: if (snap_valid_i && snap_i.tag.complete) state_d = E_CMP;
      E_CMP: begin
        if (prev_valid_q && same) begin
          state_d = cend_q ? E_MARK : E_IDLE;
        end else begin
          state_d = E_RUN;
        end
      end
      E_RUN:  if (slot_free && run_last) state_d = E_IDLE;
      E_MARK: if (slot_free) state_d = E_IDLE;
      default: state_d = E_IDLE;
    endcase
  end

  // control registers and previous point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= E_IDLE;
      prev_valid_q <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      for (int j = 0; j < DIMS; j++) prev_q[j] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == E_CMP) begin
        prev_valid_q <= !cend_q;
        idx_q        <= '0;
        if (!(prev_valid_q && same)) begin
          for (int j = 0; j < DIMS; j++) prev_q[j] <= cur_q[j];
        end
      end
      if (state_q == E_RUN && slot_free) idx_q <= idx_q + 1'b1;
      // output register handshake
      if ((state_q == E_RUN || state_q == E_MARK) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // coordinate store and output payload
  always_ff @(posedge clk_i) begin
    if (state_q == E_IDLE && snap_valid_i) begin
      cur_q[snap_i.tag.dim] <= snap_i.value;
      cend_q                <= snap_i.tag.curve_end;
    end
    if (state_q == E_RUN && slot_free) begin
      out_value_q  <= cur_q[idx_q];
      out_plast_q  <= run_last;
      out_clast_q  <= run_last && cend_q;
      out_marker_q <= 1'b0;
    end else if (state_q == E_MARK && slot_free) begin
      out_value_q  <= '0;
      out_plast_q  <= 1'b0;
      out_clast_q  <= 1'b1;
      out_marker_q <= 1'b1;
    end
  end

  assign snap_ready_o           = (state_q == E_IDLE);
  assign result_o.valid         = out_valid_q;
  assign result_o.snapped_value = out_value_q;
  assign result_o.point_last    = out_plast_q;
  assign result_o.curve_last    = out_clast_q;
  assign result_o.marker_only   = out_marker_q;

endmodule

@@ hdl/curve_grid_snap_dedup.sv @@
// ----------------------------------------------------------------------------
// curve_grid_snap_dedup: shifted grid snapping with duplicate point removal
// Snaps signed Q16.16 curve coordinates to a per-dimension shifted grid and
// drops points equal to the previous point of the same curve.
// ----------------------------------------------------------------------------
// Coordinates arrive one beat each, dimensions in order; a point closes on
// point_end, on curve_end or on its last dimension. Each coordinate passes
// through offset removal, the bit-serial remainder unit, which takes one bit
// of the 32-bit offset magnitude per cycle, rounding and saturation to a
// snapped value; the next coordinate is taken only once that value has been
// handed on to point assembly, which is held off while a run waits on the
// output. A new point leaves as a run of one beat per dimension through an
// output register, a repeated point leaves nothing, and a repeated point at
// curve end leaves a single marker beat. Configuration writes are always
// taken and must only be issued while the block is idle.
module curve_grid_snap_dedup (
  input  logic      clk_i,
  input  logic      rst_ni,
  csd_coord_if.sink coord_i,
  csd_res_if.source result_o,
  csd_cfg_if.sink   cfg_i
);
  import csd_pkg::*;

  logic [StepW-1:0] grid_step_q;
  logic [StepW-1:0] shift_q [NumShift];
  logic [DimW-1:0]  dim_q;
  logic [StepW-1:0] step_eff;
  logic [ShIdxW-1:0] sh_idx;
  logic             accept;
  logic             snap_idle;
  logic             snap_valid;
  logic             snap_ready;
  snap_res_t        snap_res;
  coord_tag_t       tag;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_step_q <= GridStepRst;
      for (int i = 0; i < NumShift; i++) shift_q[i] <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_GRID_STEP: grid_step_q <= cfg_i.data[StepW-1:0];
        REG_SHIFT_0:   shift_q[0]  <= cfg_i.data[StepW-1:0];
        REG_SHIFT_1:   shift_q[1]  <= cfg_i.data[StepW-1:0];
        REG_SHIFT_2:   shift_q[2]  <= cfg_i.data[StepW-1:0];
        REG_SHIFT_3:   shift_q[3]  <= cfg_i.data[StepW-1:0];
        default: ;
      endcase
    end
  end

  // zero pitch behaves as the smallest pitch
  assign step_eff = (grid_step_q == '0) ? StepW'(1) : grid_step_q;

  // input beat acceptance and dimension tracking
  assign coord_i.ready = snap_idle;
  assign accept        = coord_i.valid && snap_idle;
  assign sh_idx        = ShIdxW'(dim_q);

  assign tag.dim       = dim_q;
  assign tag.complete  = coord_i.point_end || coord_i.curve_end ||
                         (dim_q == DimW'(DIMS - 1));
  assign tag.curve_end = coord_i.curve_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= '0;
    end else if (accept) begin
      dim_q <= tag.complete ? '0 : (dim_q + 1'b1);
    end
  end

  // snapping unit
  csd_snap u_snap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .coord_i     (coord_i.coord_value),
    .shift_i     (shift_q[sh_idx]),
    .step_i      (step_eff),
    .tag_i       (tag),
    .idle_o      (snap_idle),
    .res_valid_o (snap_valid),
    .res_o       (snap_res),
    .res_ready_i (snap_ready)
  );

  // point assembly and output sequencing
  csd_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_i       (snap_res),
    .snap_ready_o (snap_ready),
    .result_o     (result_o)
  );

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the curve grid snap and dedup block
// Drives coordinate beats with bursty gaps against a stalling result sink,
// predicts every snapped run, marker and dropped repeat, and compares each
// result beat field by field. A directed opening covers tie rounding,
// negative offsets, clamping, zero pitch and curve-end markers. Random grid
// settings then run well-formed curves with repeats, jitter and noise.
// ----------------------------------------------------------------------------
module testbench;
  import csd_pkg::*;

  // one result beat as it leaves the block
  typedef struct packed {
    logic [31:0] value;
    logic        point_last;
    logic        curve_last;
    logic        marker_only;
  } snap_beat_t;

  // snapping predictor plus queue of result beats still owed by the block
  class grid_snap_scoreboard;
    logic [30:0] step;
    logic [30:0] shift_reg [NumShift];
    logic [31:0] cur_pt [NumShift];
    logic [31:0] prev_pt [NumShift];
    logic        prev_valid;
    logic [1:0]  dim_idx;
    snap_beat_t  owed_beats [$];
    int errors, coords, points_out, dups, markers, clamped, beats_seen;

    function new();
      step = GridStepRst;
      for (int i = 0; i < NumShift; i++) begin
        shift_reg[i] = '0;
        cur_pt[i]    = '0;
        prev_pt[i]   = '0;
      end
      prev_valid = 1'b0;
      dim_idx    = '0;
    endfunction

    // floor-based snap to the shifted grid, ties go down, clamp to 32 bit
    function logic [31:0] snap(logic signed [31:0] x, logic [30:0] sh);
      longint pitch, off, q, r, y;
      pitch = (step == '0) ? 64'sd1 : longint'(step);
      off   = longint'(x) - longint'(sh);
      q     = off / pitch;
      r     = off - q * pitch;
      if (r < 0) begin
        r += pitch;
        q -= 1;
      end
      if (2 * r > pitch) q += 1;
      y = q * pitch + longint'(sh);
      if (y > 64'sd2147483647) begin
        y = 64'sd2147483647;
        clamped++;
      end else if (y < -64'sd2147483648) begin
        y = -64'sd2147483648;
        clamped++;
      end
      return y[31:0];
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (cfg_reg_e'(idx))
        REG_GRID_STEP: step = data[30:0];
        REG_SHIFT_0:   shift_reg[0] = data[30:0];
        REG_SHIFT_1:   shift_reg[1] = data[30:0];
        REG_SHIFT_2:   shift_reg[2] = data[30:0];
        REG_SHIFT_3:   shift_reg[3] = data[30:0];
        default: ;
      endcase
    endfunction

    // append a beat to the tail of the owed queue
    function void owe_beat(snap_beat_t b);
      owed_beats = {owed_beats, b};
    endfunction

    // accepted coordinate beat: store it, and on point close emit, drop or mark
    function void accept_coord(logic signed [31:0] x, logic pe, logic ce);
      logic [1:0] d;
      bit         same;
      snap_beat_t b;
      coords++;
      d = dim_idx;
      cur_pt[d] = snap(x, shift_reg[d]);
      if (!(pe || ce || d >= DIMS - 1)) begin
        dim_idx = d + 2'd1;
        return;
      end
      dim_idx = '0;
      same = 1'b1;
      for (int j = 0; j < DIMS; j++)
        if (cur_pt[j] != prev_pt[j]) same = 1'b0;
      if (prev_valid && same) begin
        dups++;
        // repeated point closing a curve still has to carry the curve end
        if (ce) begin
          b = '{value: '0, point_last: 1'b0, curve_last: 1'b1, marker_only: 1'b1};
          owe_beat(b);
          markers++;
        end
      end else begin
        points_out++;
        for (int j = 0; j < DIMS; j++) begin
          b.value       = cur_pt[j];
          b.point_last  = (j == DIMS - 1);
          b.curve_last  = (j == DIMS - 1) && ce;
          b.marker_only = 1'b0;
          owe_beat(b);
          prev_pt[j] = cur_pt[j];
        end
        prev_valid = 1'b1;
      end
      if (ce) prev_valid = 1'b0;
    endfunction

    function void report(string what, snap_beat_t want, snap_beat_t got);
      errors++;
      if (errors <= 10)
        $display("mismatch %0d: %s, expected %0d/%b%b%b got %0d/%b%b%b", errors, what,
                 $signed(want.value), want.point_last, want.curve_last, want.marker_only,
                 $signed(got.value), got.point_last, got.curve_last, got.marker_only);
    endfunction

    function void check_beat(snap_beat_t got);
      snap_beat_t want;
      beats_seen++;
      if (owed_beats.size() == 0) begin
        report("beat with nothing owed", '0, got);
        return;
      end
      want = owed_beats.pop_front();
      if (got.value !== want.value || got.point_last !== want.point_last ||
          got.curve_last !== want.curve_last || got.marker_only !== want.marker_only)
        report("wrong beat", want, got);
    endfunction
  endclass

  localparam int CycleLimit  = 400000;
  localparam int SettleCycles = 100;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   cycle_count = 0;
  int   burst_left  = 0;
  int   settings    = 0;

  grid_snap_scoreboard sb = new();

  csd_coord_if coord_ch ();
  csd_res_if   res_ch ();
  csd_cfg_if   cfg_ch ();

  curve_grid_snap_dedup dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .coord_i  (coord_ch),
    .result_o (res_ch),
    .cfg_i    (cfg_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // sample every handshake at the rising edge
  always @(posedge clk_i) begin
    if (res_ch.valid && res_ch.ready)
      sb.check_beat(snap_beat_t'{res_ch.snapped_value, res_ch.point_last,
                                 res_ch.curve_last, res_ch.marker_only});
    if (coord_ch.valid && coord_ch.ready)
      sb.accept_coord(coord_ch.coord_value, coord_ch.point_end, coord_ch.curve_end);
    if (cfg_ch.valid && cfg_ch.ready)
      sb.write_reg(cfg_ch.index, cfg_ch.data);
  end

  // result sink: stretches of always-ready, random, mostly stalled and periodic
  initial begin : result_sink
    int mode;
    int span;
    res_ch.ready = 1'b0;
    mode = 0;
    span = 0;
    forever begin
      @(negedge clk_i);
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(10, 150);
      end
      span--;
      case (mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= 1'($urandom_range(0, 1));
        2: res_ch.ready <= ($urandom_range(0, 3) == 0);
        default: res_ch.ready <= (cycle_count % 3 == 0);
      endcase
    end
  end

  task automatic pause_sender(int n);
    repeat (n) begin
      @(negedge clk_i);
      coord_ch.valid       <= 1'b0;
      coord_ch.coord_value <= $urandom;
    end
  endtask

  task automatic wait_drained();
    while (sb.owed_beats.size() != 0) @(posedge clk_i);
    // a dropped repeat or an open point may still be in the divider
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic end_phase();
    pause_sender(1);
    wait_drained();
  endtask

  task automatic send_coord(logic [31:0] x, logic pe, logic ce);
    @(negedge clk_i);
    coord_ch.valid       <= 1'b1;
    coord_ch.coord_value <= x;
    coord_ch.point_end   <= pe;
    coord_ch.curve_end   <= ce;
    do @(posedge clk_i); while (coord_ch.ready !== 1'b1);
  endtask

  // bursty sender, now and then holding off until all owed beats are out
  task automatic feed_coord(logic [31:0] x, logic pe, logic ce);
    if (burst_left == 0) begin
      pause_sender($urandom_range(1, 12));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
    end else if ($urandom_range(0, 59) == 0) begin
      end_phase();
    end
    burst_left--;
    send_coord(x, pe, ce);
  endtask

  task automatic write_cfg(cfg_reg_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_setting(logic [31:0] pitch, logic [31:0] s0, logic [31:0] s1,
                               logic [31:0] s2, logic [31:0] s3);
    write_cfg(REG_GRID_STEP, pitch);
    write_cfg(REG_SHIFT_0, s0);
    write_cfg(REG_SHIFT_1, s1);
    write_cfg(REG_SHIFT_2, s2);
    write_cfg(REG_SHIFT_3, s3);
    settings++;
  endtask

  // random pitch from zero up to full scale, shifts mostly below the pitch
  task automatic random_setting();
    logic [30:0] pitch;
    logic [31:0] sh [NumShift];
    case ($urandom_range(0, 9))
      0:       pitch = '0;
      1:       pitch = 31'h7FFF_FFFF;
      2, 3, 4: pitch = 31'($urandom_range(1, 4096));
      5, 6:    pitch = 31'($urandom_range(4097, 32'h0010_0000));
      default: pitch = 31'($urandom_range(1, 32'h7FFF_FFFF));
    endcase
    for (int i = 0; i < NumShift; i++) begin
      if (pitch <= 1 || $urandom_range(0, 7) == 0)
        sh[i] = $urandom;
      else
        sh[i] = {1'($urandom_range(0, 1)), 31'($urandom_range(0, pitch - 1))};
    end
    apply_setting({1'($urandom_range(0, 1)), pitch}, sh[0], sh[1], sh[2], sh[3]);
  endtask

  // grid pitch as a distance for picking coordinates, capped to stay in range
  function automatic longint grid_span();
    longint s;
    s = (sb.step == '0) ? 64'sd1 : longint'(sb.step);
    if (s > 64'sd268435456) s = 64'sd268435456;
    return s;
  endfunction

  function automatic logic [31:0] near(logic [31:0] c, longint reach);
    longint v;
    v = longint'($signed(c)) + longint'($urandom_range(0, 32'(2 * reach))) - reach;
    return v[31:0];
  endfunction

  function automatic logic [31:0] wild(logic [31:0] c);
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      8:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
      9:       return 32'h8000_0000 + $urandom_range(0, 3);
      default: return near(c, 3 * grid_span());
    endcase
  endfunction

  // well-formed curves with repeated, jittered and fresh points, some noise
  task automatic random_phase(int n_items);
    logic [31:0] pt [DIMS];
    logic [31:0] center [DIMS];
    int   sent;
    int   npts;
    int   ncoords;
    int   r;
    logic pe;
    logic ce;
    sent = 0;
    for (int j = 0; j < DIMS; j++) pt[j] = wild(32'h0);
    while (sent < n_items) begin
      npts = $urandom_range(1, 6);
      for (int j = 0; j < DIMS; j++) center[j] = wild(32'h0);
      for (int p = 0; p < npts; p++) begin
        r = $urandom_range(0, 99);
        if (r >= 55) begin
          for (int j = 0; j < DIMS; j++) pt[j] = wild(center[j]);
        end else if (r >= 30) begin
          for (int j = 0; j < DIMS; j++) pt[j] = near(pt[j], grid_span() / 3 + 1);
        end
        // short point keeps the stored value of its missing dimensions
        ncoords = DIMS;
        if (DIMS > 1 && $urandom_range(0, 9) == 0) ncoords = $urandom_range(1, DIMS - 1);
        for (int j = 0; j < ncoords; j++) begin
          ce = (p == npts - 1) && (j == ncoords - 1);
          pe = (j == ncoords - 1) && (ncoords < DIMS || $urandom_range(0, 3) != 0);
          feed_coord(pt[j], pe, ce);
          sent++;
        end
        if ($urandom_range(0, 24) == 0) begin
          feed_coord($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
    end_phase();
  endtask

  initial begin : stimulus
    coord_ch.valid       = 1'b0;
    coord_ch.coord_value = '0;
    coord_ch.point_end   = 1'b0;
    coord_ch.curve_end   = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_GRID_STEP;
    cfg_ch.data          = '0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset grid: full first point so every dimension is written early
    feed_coord(32'd100, 1'b0, 1'b0);
    feed_coord(-32'sd100, 1'b1, 1'b0);
    // same snapped point, closed by the last dimension alone: dropped
    feed_coord(32'd200, 1'b0, 1'b0);
    feed_coord(-32'sd250, 1'b0, 1'b0);
    // half-pitch ties round down on both signs, closes the curve
    feed_coord(32'd295, 1'b0, 1'b0);
    feed_coord(-32'sd295, 1'b0, 1'b1);
    // new curve, then a repeat at curve end gives a marker beat
    feed_coord(32'd10, 1'b0, 1'b0);
    feed_coord(32'd20, 1'b1, 1'b0);
    feed_coord(32'd0, 1'b0, 1'b0);
    feed_coord(32'd5, 1'b1, 1'b1);
    // short point, then a short repeat closed by curve end only
    feed_coord(32'd3000, 1'b1, 1'b0);
    feed_coord(32'd2960, 1'b0, 1'b1);
    // full-scale inputs clamp at both ends
    feed_coord(32'h7FFF_FFFF, 1'b0, 1'b0);
    feed_coord(32'h8000_0000, 1'b1, 1'b1);
    end_phase();

    // tie rounding with an offset grid and negative offsets
    apply_setting(32'd100, 32'd0, 32'd30, $urandom, $urandom);
    feed_coord(32'd50, 1'b0, 1'b0);
    feed_coord(32'd80, 1'b1, 1'b0);
    feed_coord(-32'sd50, 1'b0, 1'b0);
    feed_coord(-32'sd20, 1'b1, 1'b1);
    end_phase();

    // zero pitch passes values through, shifts above the pitch
    apply_setting(32'd0, 32'h7FFF_FFFF, 32'h4000_0000, 32'h0, 32'h7FFF_FFFF);
    feed_coord(32'h8000_0000, 1'b0, 1'b0);
    feed_coord(32'h7FFF_FFFF, 1'b1, 1'b0);
    end_phase();

    // widest pitch and shift, top data bit set on the writes
    apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h0);
    feed_coord(32'h8000_0000, 1'b0, 1'b0);
    feed_coord(32'hFFFF_FFFF, 1'b1, 1'b1);
    end_phase();

    // coarse grid pushes snapped values past both ends of the range
    apply_setting(32'h5000_0000, 32'h0, 32'h0, 32'h0, 32'h0);
    feed_coord(32'h7FFF_FFFF, 1'b0, 1'b0);
    feed_coord(32'h8000_0000, 1'b1, 1'b1);
    end_phase();

    for (int ph = 0; ph < 8; ph++) begin
      random_setting();
      random_phase(48);
    end

    sb.errors += sb.owed_beats.size();
    $display("testbench: %0d coordinates, %0d grid settings, %0d points out, %0d dropped",
             sb.coords, settings + 1, sb.points_out, sb.dups);
    $display("testbench: %0d markers, %0d clamped, %0d beats checked, %0d errors",
             sb.markers, sb.clamped, sb.beats_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/csd_pkg.sv
hdl/csd_intf.sv
hdl/csd_rem_div.sv
hdl/csd_snap.sv
hdl/csd_emit.sv
hdl/curve_grid_snap_dedup.sv
sim/testbench.sv
